// ----- rtl/kdce_pkg.sv -----
// ----------------------------------------------------------------------------
// kdce_pkg: shared types and constants for the knob code entry panel
// Phase, key, status and sequencer codes, field widths and the control
// bundle that drives the shared arithmetic unit.
// ----------------------------------------------------------------------------
package kdce_pkg;

	localparam int MAX_DIGITS = 8;
	localparam int DIG_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W      = 4;
	localparam int BASE_W     = 5;
	localparam int NIB_W      = 4;
	localparam int VAL_W      = 32;
	localparam int WORD_W     = NIB_W * MAX_DIGITS;
	localparam int NIB_CNT_W  = $clog2(VAL_W / NIB_W);

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_DIGIT_BASE  = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_DIGIT_COUNT = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PAGE = 2'd1,
		PH_EDIT = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		KEY_ADVANCE  = 3'd0,
		KEY_LEFT     = 3'd1,
		KEY_RIGHT    = 3'd2,
		KEY_FUNCTION = 3'd3,
		KEY_COMMIT   = 3'd4,
		KEY_OTHER    = 3'd5
	} key_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_SAVED = 2'd1,
		ST_LEFT  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ED_NONE = 2'd0,
		ED_DEC  = 2'd1,
		ED_INC  = 2'd2
	} edit_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_DIV  = 2'd1,
		S_WALK = 2'd2,
		S_FIN  = 2'd3
	} seq_state_t;

	typedef enum logic {
		UOP_DIV = 1'b0,
		UOP_MAC = 1'b1
	} unit_op_t;

	typedef struct packed {
		unit_op_t            op;
		logic [BASE_W-1:0]   base;
	} unit_ctl_t;

endpackage

// ----- rtl/knob_digit_code_entry.sv -----
// ----------------------------------------------------------------------------
// knob_digit_code_entry: rotary-knob code entry panel
// Loads a code as base-N digits, edits them under a cursor with knob keys
// and packs them back into a code on commit.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+------------------------------------
//  s_*      | in        | s_tvalid / s_tready  | tuser: mode; tdata: key, load_value
//  m_*      | out       | m_tvalid / m_tready  | tdata: digit_word, cursor, phase,
//           |           |                      |        status, code_value
//  cfg_*    | in        | cfg_we (no wait)     | cfg_addr register index, cfg_wdata
//
//  A key event runs a walk over all digit slots through the shared
//  multiply-accumulate, then the final state loads the output register.
//  A load first runs the shared divide step for every digit in use, which
//  retires four quotient bits a cycle. s_tready is high only while the
//  sequencer is idle; a finished item holds in the final state until the
//  output register frees. Reset restores defaults.
// ----------------------------------------------------------------------------
module knob_digit_code_entry
	import kdce_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,   // [2:0] key, [34:3] load_value, rest zero
	input  logic [0:0]            s_tuser,   // [0] mode
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [71:0]           m_tdata,   // [31:0] digit_word, [34:32] cursor,
	                                         // [36:35] phase, [38:37] status,
	                                         // [70:39] code_value, [71] zero
	// configuration
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_addr,
	input  logic [BASE_W-1:0]     cfg_wdata
);

	// configuration
	logic [BASE_W-1:0]  base_q;
	logic [CNT_W-1:0]   count_q;
	logic [BASE_W-1:0]  base_eff;
	logic [CNT_W-1:0]   cnt_eff;
	logic [CNT_W-1:0]   cnt_m1;

	// architectural state
	logic [NIB_W-1:0]   digits_q [MAX_DIGITS];
	logic [DIG_W-1:0]   cursor_q;
	phase_t             phase_q;

	// sequencer
	seq_state_t         state_q, state_d;
	logic [NIB_CNT_W-1:0] nib_q;
	logic [DIG_W-1:0]   dig_q;
	logic [DIG_W-1:0]   idx_q;
	edit_t              edit_q;
	status_t            status_q;

	// datapath
	logic [VAL_W-1:0]   val_q;
	logic [NIB_W-1:0]   rem_q;
	logic [VAL_W-1:0]   acc_q;
	logic [WORD_W-1:0]  word_q;

	// output register
	logic               out_valid_q;
	logic [WORD_W-1:0]  out_word_q;
	logic [DIG_W-1:0]   out_cursor_q;
	phase_t             out_phase_q;
	status_t            out_status_q;
	logic [VAL_W-1:0]   out_code_q;

	// input fields
	logic               in_mode;
	key_t               in_key;
	logic [VAL_W-1:0]   in_load;
	logic               accept;

	// accept decode
	phase_t             phase_nx;
	logic [DIG_W-1:0]   cursor_nx;
	edit_t              edit_nx;
	status_t            status_nx;

	// shared unit
	unit_ctl_t          ctl;
	logic [VAL_W-1:0]   u_operand;
	logic [NIB_W-1:0]   u_digit;
	logic [VAL_W-1:0]   u_result;
	logic [NIB_W-1:0]   u_rem;

	// walk and divide helpers
	logic [NIB_W-1:0]   bm1;
	logic [NIB_W-1:0]   cur_dig;
	logic [NIB_W-1:0]   new_dig;
	logic               in_use;
	logic [DIG_W-1:0]   load_idx;
	logic               nib_last;
	logic               dig_last;
	logic               walk_last;
	logic               out_free;

	assign in_mode = s_tuser[0];
	assign in_key  = key_t'(s_tdata[2:0]);
	assign in_load = s_tdata[34:3];

	// clamp the base to 2..16 and the count to 1..MAX_DIGITS
	always_comb begin
		if (base_q < BASE_MIN)
			base_eff = BASE_MIN;
		else if (base_q > BASE_MAX)
			base_eff = BASE_MAX;
		else
			base_eff = base_q;
		if (count_q == '0)
			cnt_eff = CNT_W'(1);
		else if (count_q > CNT_W'(MAX_DIGITS))
			cnt_eff = CNT_W'(MAX_DIGITS);
		else
			cnt_eff = count_q;
	end

	assign cnt_m1 = cnt_eff - CNT_W'(1);
	assign bm1    = NIB_W'(base_eff - BASE_W'(1));

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// decode a key event against the current phase
	always_comb begin
		phase_nx  = phase_q;
		cursor_nx = cursor_q;
		edit_nx   = ED_NONE;
		status_nx = ST_NONE;
		case (phase_q)
			PH_PAGE: begin
				case (in_key)
					KEY_COMMIT: begin
						phase_nx  = PH_EDIT;
						cursor_nx = '0;
					end
					KEY_FUNCTION: begin
						phase_nx  = PH_IDLE;
						cursor_nx = '0;
						status_nx = ST_LEFT;
					end
					default: ;
				endcase
			end
			PH_EDIT: begin
				case (in_key)
					KEY_ADVANCE: begin
						// wrap after the last digit in use, also when the
						// cursor already sits beyond a lowered count
						if ({1'b0, cursor_q} >= cnt_m1)
							cursor_nx = '0;
						else
							cursor_nx = cursor_q + DIG_W'(1);
					end
					KEY_LEFT:  edit_nx = ED_DEC;
					KEY_RIGHT: edit_nx = ED_INC;
					KEY_FUNCTION: begin
						phase_nx  = PH_IDLE;
						cursor_nx = '0;
						status_nx = ST_LEFT;
					end
					KEY_COMMIT: begin
						phase_nx  = PH_IDLE;
						cursor_nx = '0;
						status_nx = ST_SAVED;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// digit under the walk pointer, with the knob edit applied at the cursor
	assign cur_dig = digits_q[idx_q];
	always_comb begin
		new_dig = cur_dig;
		if (idx_q == cursor_q) begin
			case (edit_q)
				ED_DEC: new_dig = (cur_dig == '0) ? bm1 : cur_dig - NIB_W'(1);
				// a digit left above a lowered base wraps to zero
				ED_INC: new_dig = (cur_dig >= bm1) ? '0 : cur_dig + NIB_W'(1);
				default: new_dig = cur_dig;
			endcase
		end
	end

	assign in_use    = ({1'b0, idx_q} < cnt_eff);
	assign load_idx  = cnt_m1[DIG_W-1:0] - dig_q;
	assign nib_last  = (nib_q == NIB_CNT_W'((VAL_W / NIB_W) - 1));
	assign dig_last  = ({1'b0, dig_q} == cnt_m1);
	assign walk_last = (idx_q == DIG_W'(MAX_DIGITS - 1));

	// shared unit steering
	always_comb begin
		ctl.base  = base_eff;
		u_digit   = new_dig;
		if (state_q == S_DIV) begin
			ctl.op    = UOP_DIV;
			u_operand = val_q;
		end else begin
			ctl.op    = UOP_MAC;
			u_operand = acc_q;
		end
	end

	kdce_unit u_unit (
		.ctl     (ctl),
		.operand (u_operand),
		.rem_in  (rem_q),
		.digit   (u_digit),
		.result  (u_result),
		.rem_out (u_rem)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = in_mode ? S_WALK : S_DIV;
			S_DIV:  if (nib_last && dig_last) state_d = S_WALK;
			S_WALK: if (walk_last) state_d = S_FIN;
			S_FIN:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, architectural state and sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= BASE_W'(8);
			count_q     <= CNT_W'(4);
			for (int i = 0; i < MAX_DIGITS; i++)
				digits_q[i] <= '0;
			cursor_q    <= '0;
			phase_q     <= PH_IDLE;
			nib_q       <= '0;
			dig_q       <= '0;
			idx_q       <= '0;
			edit_q      <= ED_NONE;
			status_q    <= ST_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DIGIT_BASE:  base_q  <= cfg_wdata;
					REG_DIGIT_COUNT: count_q <= cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						nib_q <= '0;
						dig_q <= '0;
						if (!in_mode) begin
							// digits past the count read back as zero
							for (int i = 0; i < MAX_DIGITS; i++)
								digits_q[i] <= '0;
							cursor_q <= '0;
							phase_q  <= PH_PAGE;
							edit_q   <= ED_NONE;
							status_q <= ST_NONE;
						end else begin
							cursor_q <= cursor_nx;
							phase_q  <= phase_nx;
							edit_q   <= edit_nx;
							status_q <= status_nx;
						end
					end
				end
				S_DIV: begin
					nib_q <= nib_q + NIB_CNT_W'(1);
					if (nib_last) begin
						// remainder is the next digit, lowest first
						digits_q[load_idx] <= u_rem;
						dig_q <= dig_q + DIG_W'(1);
					end
				end
				S_WALK: begin
					digits_q[idx_q] <= new_dig;
					idx_q <= idx_q + DIG_W'(1);
				end
				default: ;
			endcase

			if (state_q == S_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q  <= in_load;
					rem_q  <= '0;
					acc_q  <= '0;
					word_q <= '0;
				end
			end
			S_DIV: begin
				val_q <= u_result;
				rem_q <= nib_last ? '0 : u_rem;
			end
			S_WALK: begin
				if (in_use) begin
					acc_q  <= u_result;
					word_q <= {word_q[WORD_W-NIB_W-1:0], new_dig};
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_word_q   <= word_q;
					out_cursor_q <= cursor_q;
					out_phase_q  <= phase_q;
					out_status_q <= status_q;
					out_code_q   <= (status_q == ST_SAVED) ? acc_q : '0;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_code_q, out_status_q, out_phase_q, out_cursor_q, out_word_q};

`ifndef SYNTH
	// the partial remainder stays below the base through every divide step
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> {1'b0, rem_q} < base_eff)
		else $error("divide remainder reached the base");

	// the sequencer is busy in the cycle after a transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while sequencer busy");

	// leaving the page always parks the cursor
	a_idle_cursor_home: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cursor_q == '0)
		else $error("cursor off home while idle");

	// a saved code is reported only with the panel back at idle
	a_saved_is_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_status_q == ST_SAVED |-> out_phase_q == PH_IDLE)
		else $error("saved status outside idle phase");

	// code_value is zero unless the code was saved
	a_code_only_saved: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_status_q != ST_SAVED |-> out_code_q == '0)
		else $error("code value without save");
`endif

endmodule

// ----- rtl/kdce_unit.sv -----
// ----------------------------------------------------------------------------
// kdce_unit: shared arithmetic unit
// Divide step: shifts four dividend bits through a radix-2 restoring divide
// by the digit base. Multiply-accumulate: operand * base + digit.
// ----------------------------------------------------------------------------
module kdce_unit
	import kdce_pkg::*;
(
	input  unit_ctl_t          ctl,
	input  logic [VAL_W-1:0]   operand,
	input  logic [NIB_W-1:0]   rem_in,
	input  logic [NIB_W-1:0]   digit,
	output logic [VAL_W-1:0]   result,
	output logic [NIB_W-1:0]   rem_out
);

	logic [NIB_W-1:0]      qbits;
	logic [NIB_W-1:0]      r;
	logic [NIB_W:0]        t;
	logic [VAL_W+BASE_W-1:0] prod;

	// four dependent compare/subtract steps on a 5-bit partial remainder
	always_comb begin
		r     = rem_in;
		qbits = '0;
		t     = '0;
		for (int j = 0; j < NIB_W; j++) begin
			t = {r, operand[VAL_W-1-j]};
			if (t >= ctl.base) begin
				qbits[NIB_W-1-j] = 1'b1;
				t = t - ctl.base;
			end
			r = t[NIB_W-1:0];
		end
	end

	assign prod = operand * ctl.base;

	always_comb begin
		case (ctl.op)
			UOP_DIV: begin
				result  = {operand[VAL_W-NIB_W-1:0], qbits};
				rem_out = r;
			end
			UOP_MAC: begin
				result  = prod[VAL_W-1:0] + {{(VAL_W-NIB_W){1'b0}}, digit};
				rem_out = '0;
			end
			default: begin
				result  = '0;
				rem_out = '0;
			end
		endcase
	end

endmodule

// ----- dv/code_entry_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// code_entry_checker: result predictor and comparator for the code entry panel
// Follows register writes and input transfers to predict each result of the
// panel, then compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module code_entry_checker
	import kdce_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [39:0]          s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [71:0]          m_tdata,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_addr,
	input  logic [BASE_W-1:0]    cfg_wdata,
	output int                   errors,
	output int                   pending
);

	// same bit layout as m_tdata, lowest field last
	typedef struct packed {
		logic              pad;
		logic [VAL_W-1:0]  code;
		status_t           status;
		phase_t            phase;
		logic [DIG_W-1:0]  cursor;
		logic [WORD_W-1:0] word;
	} panel_result_t;

	logic [BASE_W-1:0] base_reg;
	logic [CNT_W-1:0]  count_reg;
	logic [NIB_W-1:0]  digit_q [MAX_DIGITS];
	logic [DIG_W-1:0]  cursor_q;
	phase_t            phase_q;

	panel_result_t     expected_results [$];
	panel_result_t     want;
	panel_result_t     got;

	function automatic int unsigned base_in_use();
		if (base_reg < BASE_MIN)
			return BASE_MIN;
		if (base_reg > BASE_MAX)
			return BASE_MAX;
		return base_reg;
	endfunction

	function automatic int unsigned count_in_use();
		if (count_reg < 1)
			return 1;
		if (count_reg > MAX_DIGITS)
			return MAX_DIGITS;
		return count_reg;
	endfunction

	// advance the panel by one input item and return the result it produces
	function automatic panel_result_t panel_step(logic is_key, logic [2:0] key,
			logic [VAL_W-1:0] value);
		panel_result_t r;
		int unsigned   b;
		int unsigned   n;
		int unsigned   v;
		logic [63:0]   acc;
		logic [DIG_W-1:0] cur;
		b      = base_in_use();
		n      = count_in_use();
		cur    = cursor_q;
		r      = '0;
		r.status = ST_NONE;
		if (!is_key) begin
			v = value;
			for (int i = 0; i < MAX_DIGITS; i++)
				digit_q[i] = '0;
			for (int k = 0; k < n; k++) begin
				digit_q[n-1-k] = NIB_W'(v % b);
				v = v / b;
			end
			cursor_q = '0;
			phase_q  = PH_PAGE;
		end else if (phase_q == PH_PAGE) begin
			if (key == KEY_COMMIT) begin
				phase_q  = PH_EDIT;
				cursor_q = '0;
			end else if (key == KEY_FUNCTION) begin
				phase_q  = PH_IDLE;
				cursor_q = '0;
				r.status = ST_LEFT;
			end
		end else if (phase_q == PH_EDIT) begin
			case (key)
				KEY_ADVANCE: cursor_q = (cur >= n - 1) ? '0 : DIG_W'(cur + 1);
				KEY_LEFT: begin
					if (digit_q[cur] == 0)
						digit_q[cur] = NIB_W'(b - 1);
					else
						digit_q[cur] = digit_q[cur] - 1'b1;
				end
				KEY_RIGHT: begin
					if (digit_q[cur] >= b - 1)
						digit_q[cur] = '0;
					else
						digit_q[cur] = digit_q[cur] + 1'b1;
				end
				KEY_FUNCTION: begin
					phase_q  = PH_IDLE;
					cursor_q = '0;
					r.status = ST_LEFT;
				end
				KEY_COMMIT: begin
					acc = '0;
					for (int i = 0; i < n; i++)
						acc = acc * 64'(b) + 64'(digit_q[i]);
					r.code   = acc[VAL_W-1:0];
					phase_q  = PH_IDLE;
					cursor_q = '0;
					r.status = ST_SAVED;
				end
				default: ;
			endcase
		end
		for (int i = 0; i < n; i++)
			r.word = {r.word[WORD_W-NIB_W-1:0], digit_q[i]};
		r.cursor = cursor_q;
		r.phase  = phase_q;
		return r;
	endfunction

	task automatic check_field(string name, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg  = BASE_W'(8);
			count_reg = CNT_W'(4);
			for (int i = 0; i < MAX_DIGITS; i++)
				digit_q[i] = '0;
			cursor_q = '0;
			phase_q  = PH_IDLE;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_DIGIT_BASE:  base_reg  = cfg_wdata;
					REG_DIGIT_COUNT: count_reg = cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			// compare before predicting so a same-edge input never matches itself
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("digit_word", want.word, got.word);
					check_field("cursor", VAL_W'(want.cursor), VAL_W'(got.cursor));
					check_field("phase", VAL_W'(want.phase), VAL_W'(got.phase));
					check_field("status", VAL_W'(want.status), VAL_W'(got.status));
					check_field("code_value", want.code, got.code);
					check_field("pad bit", VAL_W'(want.pad), VAL_W'(got.pad));
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(panel_step(s_tuser[0], s_tdata[2:0],
					s_tdata[VAL_W+2:3]));
			pending <= expected_results.size();
		end
	end

	initial errors = 0;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the knob code entry panel
// Drives load and key items through the input stream with random gaps and
// output stalls, changes base and digit count between bursts, and lets the
// checker module predict and compare every result.
// ----------------------------------------------------------------------------
module tb
	import kdce_pkg::*;
();

	localparam int ITEM_TARGET = 1250;
	// slowest legal item is a full load plus the longest input gap and the
	// longest output stall; this leaves several times that for 1250 items
	localparam int CYCLE_LIMIT = 1_000_000;
	// longest single item (a full eight-digit load) with some margin
	localparam int TAIL_CYCLES = 90;

	// tuser flag: load a code or report a key
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_KEY  = 1'b1;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [39:0]          s_tdata   = '0;   // [2:0] key, [34:3] load_value, rest zero
	logic [0:0]           s_tuser   = '0;   // [0] mode
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [71:0]          m_tdata;          // [31:0] digit_word, [34:32] cursor,
	                                        // [36:35] phase, [38:37] status,
	                                        // [70:39] code_value, [71] zero
	logic                 cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr  = '0;
	logic [BASE_W-1:0]    cfg_wdata = '0;

	int                   errors;
	int                   pending;
	int                   cycles     = 0;
	int                   items_sent = 0;
	int unsigned          stall_left = 0;
	bit                   quiet      = 1'b0;   // no gaps and no stalls while set

	knob_digit_code_entry u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	code_entry_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: end the run with a failure once the cycle limit is reached.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Gap length for both sides: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Output side back-pressure: hold m_tready low for random stretches.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < 30)
				stall_left <= pick_gap();
		end
	end

	// Offer one item and hold it until the transfer, then idle for a gap.
	// Call right after a rising edge; s_tvalid stays high when the gap is zero.
	task automatic put_item(input logic mode, input logic [2:0] key,
			input logic [VAL_W-1:0] value);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'b0, value, key};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has come back
	// and the panel takes input again.
	task automatic drain();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || !s_tready);
	endtask

	// Register write: one strobe cycle, then release.
	task automatic cfg_write(input logic [REG_IDX_W-1:0] addr, input logic [BASE_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [BASE_W-1:0] pick_base();
		logic [BASE_W-1:0] extreme_bases [6] = '{0, 1, 2, 16, 17, 31};
		if ($urandom_range(0, 9) < 3)
			return extreme_bases[$urandom_range(0, 5)];
		return BASE_W'($urandom_range(2, 16));
	endfunction

	function automatic logic [BASE_W-1:0] pick_count();
		logic [BASE_W-1:0] extreme_counts [5] = '{0, 1, 8, 9, 15};
		if ($urandom_range(0, 9) < 3)
			return extreme_counts[$urandom_range(0, 4)];
		return BASE_W'($urandom_range(1, 8));
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 4))
			0:       return $urandom_range(0, 255);
			1:       return $urandom() >> $urandom_range(0, 31);
			2:       return $urandom_range(0, 1) ? '1 : '0;
			default: return $urandom();
		endcase
	endfunction

	// Keys while editing: mostly cursor and knob moves, some ignored codes.
	function automatic logic [2:0] pick_edit_key();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return KEY_ADVANCE;
		if (r < 55)
			return KEY_LEFT;
		if (r < 82)
			return KEY_RIGHT;
		if (r < 91)
			return KEY_OTHER;
		return 3'($urandom_range(6, 7));
	endfunction

	// One visit: load, mostly open the editor, turn the knob, mostly leave.
	// Some visits skip the load and keep editing what an earlier burst left
	// open, so a changed base or count meets digits loaded under the old one.
	task automatic edit_session();
		int unsigned n_keys;
		int unsigned ending;
		if ($urandom_range(0, 99) < 85) begin
			put_item(MODE_LOAD, 3'($urandom_range(0, 7)), pick_value());
			if ($urandom_range(0, 9) < 9)
				put_item(MODE_KEY, KEY_COMMIT, $urandom());
			else
				put_item(MODE_KEY, 3'($urandom_range(0, 7)), $urandom());
		end
		n_keys = $urandom_range(0, 16);
		repeat (n_keys) put_item(MODE_KEY, pick_edit_key(), $urandom());
		ending = $urandom_range(0, 9);
		if (ending < 6)
			put_item(MODE_KEY, KEY_COMMIT, $urandom());
		else if (ending < 8)
			put_item(MODE_KEY, KEY_FUNCTION, $urandom());
	endtask

	// One burst under one setting; ends with the sender paused until every
	// result is back, so the next burst may rewrite the registers.
	task automatic run_burst();
		int unsigned burst_len;
		int          first;
		if ($urandom_range(0, 1))
			cfg_write(REG_DIGIT_BASE, pick_base());
		if ($urandom_range(0, 1))
			cfg_write(REG_DIGIT_COUNT, pick_count());
		quiet     = ($urandom_range(0, 4) == 0);
		burst_len = $urandom_range(30, 90);
		first     = items_sent;
		while (items_sent - first < burst_len) begin
			if ($urandom_range(0, 9) == 0)
				put_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), $urandom());
			else
				edit_session();
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting (base 8, four digits): idle key, oversized load,
		// ignored page keys, knob wrap both ways, cursor wrap, ignored codes.
		put_item(MODE_KEY,  KEY_RIGHT,   32'h0);
		put_item(MODE_LOAD, KEY_ADVANCE, 32'hFFFF_FFFF);
		put_item(MODE_KEY,  KEY_OTHER,   32'h0);
		put_item(MODE_KEY,  KEY_LEFT,    32'h0);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		put_item(MODE_KEY,  KEY_RIGHT,   32'h0);
		put_item(MODE_KEY,  KEY_LEFT,    32'h0);
		repeat (4) put_item(MODE_KEY, KEY_ADVANCE, 32'h0);
		put_item(MODE_KEY,  3'd6,        32'hFFFF_FFFF);
		put_item(MODE_KEY,  3'd7,        32'h0);
		put_item(MODE_KEY,  KEY_OTHER,   32'h0);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		// leave from the page, reload while editing, leave from the editor
		put_item(MODE_LOAD, 3'd7,        32'h0);
		put_item(MODE_KEY,  KEY_FUNCTION, 32'h0);
		put_item(MODE_LOAD, KEY_ADVANCE, 32'h1234_5678);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		put_item(MODE_LOAD, KEY_ADVANCE, 32'hDEAD_BEEF);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		put_item(MODE_KEY,  KEY_FUNCTION, 32'h0);
		drain();

		// Registers above range clamp to base 16 and eight digits; park the
		// cursor on the last digit while editing.
		cfg_write(REG_DIGIT_BASE, 5'd31);
		cfg_write(REG_DIGIT_COUNT, 5'd15);
		put_item(MODE_LOAD, KEY_ADVANCE, 32'hFFFF_FFFF);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		repeat (7) put_item(MODE_KEY, KEY_ADVANCE, 32'h0);
		drain();

		// Shrink to base 2 and two digits mid-edit: knobs act on a digit past
		// the count, advance wraps, a digit above the base steps down by one.
		cfg_write(REG_DIGIT_BASE, 5'd1);
		cfg_write(REG_DIGIT_COUNT, 5'd2);
		put_item(MODE_KEY,  KEY_RIGHT,   32'h0);
		put_item(MODE_KEY,  KEY_LEFT,    32'h0);
		put_item(MODE_KEY,  KEY_ADVANCE, 32'h0);
		put_item(MODE_KEY,  KEY_LEFT,    32'h0);
		put_item(MODE_KEY,  KEY_RIGHT,   32'h0);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		drain();

		// Zero in both registers clamps to base 2 and one digit.
		cfg_write(REG_DIGIT_BASE, 5'd0);
		cfg_write(REG_DIGIT_COUNT, 5'd0);
		put_item(MODE_LOAD, KEY_ADVANCE, 32'hFFFF_FFFF);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		put_item(MODE_KEY,  KEY_RIGHT,   32'h0);
		put_item(MODE_KEY,  KEY_COMMIT,  32'h0);
		drain();

		// Random bursts until the item budget is spent.
		while (items_sent < ITEM_TARGET)
			run_burst();

		quiet = 1'b0;
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
